[design/irc_pkg.sv]
// Package for the IRC line token parser: byte codes, field kinds, result beat type.
// No dependencies; imported by irc_line_token_parser, irc_tag_monitor and tb.
`default_nettype none

package irc_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    // field_kind codes
    localparam logic [2:0] KIND_SEP     = 3'd0;
    localparam logic [2:0] KIND_PREFIX  = 3'd1;
    localparam logic [2:0] KIND_COMMAND = 3'd2;
    localparam logic [2:0] KIND_MIDDLE  = 3'd3;
    localparam logic [2:0] KIND_TRAILER = 3'd4;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] field_kind;
        logic [3:0] arg_index;
        logic       token_start;
        logic       line_end;
        logic [3:0] arg_total;
        logic       line_error;
    } t_result;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    endfunction

endpackage

`default_nettype wire

[design/irc_line_token_parser.sv]
// IRC line framer and tokenizer: one tagged result beat per input byte.
// Depends on irc_pkg (byte codes, kind codes, t_result).
//
// Usage
//   Input channel : i_valid / o_stall carry one stream byte per beat (i_data_byte).
//   Output channel: o_valid / i_stall carry one result beat per input byte, in order.
//   A beat moves on a rising edge with valid high and stall low.
// Throughput
//   The byte is classified in the cycle it is accepted and the result is
//   registered in the result register (or the skid register behind it). One byte
//   per clock is sustained while the output is not stalled; nothing else limits it.
// Stalls
//   A two-deep output (result register plus skid register) lets the block take
//   a byte while the previous result still waits. o_stall rises only once the
//   skid register is full, and it comes straight from that register.
// Reset
//   i_rst_n is synchronous, active low. It empties both output registers and
//   returns the parser to line start with no CR pending; no clearing pass.
`default_nettype none

module irc_line_token_parser #(
    parameter int MAX_ARGUMENTS  = 15,  // 1..15
    parameter int MAX_LINE_BYTES = 510  // 16..511
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input byte stream
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    // result beats
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_byte_out,
    output logic [2:0]      o_field_kind,
    output logic [3:0]      o_arg_index,
    output logic            o_token_start,
    output logic            o_line_end,
    output logic [3:0]      o_arg_total,
    output logic            o_line_error
);
    import irc_pkg::*;

    localparam logic [3:0] ARG_LIMIT = 4'(MAX_ARGUMENTS);
    localparam logic [8:0] LEN_LIMIT = 9'(MAX_LINE_BYTES);

    typedef enum logic [2:0] {
        PH_LINE_START   = 3'd0,
        PH_TRAILER_OPEN = 3'd1,  // ':' seen, next byte starts the trailer
        PH_PREFIX       = 3'd2,
        PH_CMD_WAIT     = 3'd3,
        PH_COMMAND      = 3'd4,
        PH_ARG_WAIT     = 3'd5,
        PH_MIDDLE       = 3'd6,
        PH_TRAILER      = 3'd7
    } t_phase;

    // parse state
    t_phase     r_phase, n_phase;
    logic [3:0] r_args,  n_args;   // arguments opened in this line
    logic [8:0] r_len,   n_len;    // bytes of this line kept so far
    logic       r_cr,    n_cr;     // previous byte was CR
    logic       r_ovf,   n_ovf;    // line ran past the limit

    // output register and skid register
    logic       r_o_valid, r_s_valid;
    t_result    r_o_data,  r_s_data;
    t_result    n_result;

    logic       in_fire, out_fire, ws;
    logic [3:0] arg_last;

    assign o_stall  = r_s_valid;
    assign in_fire  = i_valid && !r_s_valid;
    assign out_fire = r_o_valid && !i_stall;
    assign ws       = is_ws(i_data_byte);
    assign arg_last = r_args - 4'd1;

    // classify the byte and work out the next parse state
    always_comb begin
        n_phase  = r_phase;
        n_args   = r_args;
        n_len    = r_len;
        n_cr     = r_cr;
        n_ovf    = r_ovf;
        n_result = '{byte_out: i_data_byte, field_kind: KIND_SEP, arg_index: 4'd0,
                     token_start: 1'b0, line_end: 1'b0, arg_total: 4'd0,
                     line_error: 1'b0};

        if (i_data_byte == CH_CR || i_data_byte == CH_LF) begin
            if (i_data_byte == CH_LF && r_cr) begin
                n_cr = 1'b0;  // second half of CR LF
            end else begin
                if (r_len != 9'd0 || r_ovf) begin
                    n_result.line_end   = 1'b1;
                    n_result.arg_total  = r_args;
                    n_result.line_error = r_ovf;
                end
                n_phase = PH_LINE_START;
                n_args  = 4'd0;
                n_len   = 9'd0;
                n_ovf   = 1'b0;
                n_cr    = (i_data_byte == CH_CR);
            end
        end else begin
            n_cr = 1'b0;
            if (r_len >= LEN_LIMIT) begin
                n_ovf = 1'b1;  // dropped
            end else begin
                n_len = r_len + 9'd1;
                unique case (r_phase)
                    PH_LINE_START: begin
                        if (i_data_byte == CH_COLON) begin
                            n_phase = PH_PREFIX;
                        end else if (ws) begin
                            n_phase = PH_ARG_WAIT;
                        end else begin
                            n_result.field_kind  = KIND_COMMAND;
                            n_result.token_start = 1'b1;
                            n_phase              = PH_COMMAND;
                        end
                    end
                    PH_PREFIX: begin
                        if (ws) begin
                            n_phase = PH_CMD_WAIT;
                        end else begin
                            n_result.field_kind  = KIND_PREFIX;
                            n_result.token_start = (r_len == 9'd1);
                        end
                    end
                    PH_CMD_WAIT: begin
                        if (!ws) begin
                            n_result.field_kind  = KIND_COMMAND;
                            n_result.token_start = 1'b1;
                            n_phase              = PH_COMMAND;
                        end
                    end
                    PH_COMMAND: begin
                        if (ws) begin
                            n_phase = PH_ARG_WAIT;
                        end else begin
                            n_result.field_kind = KIND_COMMAND;
                        end
                    end
                    PH_ARG_WAIT: begin
                        if (!ws && r_args < ARG_LIMIT) begin
                            n_args = r_args + 4'd1;
                            if (i_data_byte == CH_COLON) begin
                                n_phase = PH_TRAILER_OPEN;
                            end else begin
                                n_result.field_kind  = KIND_MIDDLE;
                                n_result.token_start = 1'b1;
                                n_result.arg_index   = r_args;
                                n_phase              = PH_MIDDLE;
                            end
                        end
                    end
                    PH_MIDDLE: begin
                        if (ws) begin
                            n_phase = PH_ARG_WAIT;
                        end else begin
                            n_result.field_kind = KIND_MIDDLE;
                            n_result.arg_index  = arg_last;
                        end
                    end
                    PH_TRAILER_OPEN: begin
                        n_result.field_kind  = KIND_TRAILER;
                        n_result.token_start = 1'b1;
                        n_result.arg_index   = arg_last;
                        n_phase              = PH_TRAILER;
                    end
                    PH_TRAILER: begin
                        n_result.field_kind = KIND_TRAILER;
                        n_result.arg_index  = arg_last;
                    end
                endcase
            end
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE_START;
            r_args  <= 4'd0;
            r_len   <= 9'd0;
            r_cr    <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_args  <= n_args;
            r_len   <= n_len;
            r_cr    <= n_cr;
            r_ovf   <= n_ovf;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (r_s_valid) begin
            if (out_fire) begin
                r_o_data  <= r_s_data;
                r_s_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_o_valid || out_fire) begin
                r_o_data  <= n_result;
                r_o_valid <= 1'b1;
            end else begin
                r_s_data  <= n_result;
                r_s_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_byte_out    = r_o_data.byte_out;
    assign o_field_kind  = r_o_data.field_kind;
    assign o_arg_index   = r_o_data.arg_index;
    assign o_token_start = r_o_data.token_start;
    assign o_line_end    = r_o_data.line_end;
    assign o_arg_total   = r_o_data.arg_total;
    assign o_line_error  = r_o_data.line_error;

    // skid register only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_o_valid)
        else $error("skid register full with output register empty");

    // error and argument total only travel with a line end
    a_err_with_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_data.line_error || r_o_data.arg_total != 4'd0))
            |-> r_o_data.line_end)
        else $error("line_error or arg_total without line_end");

    // argument index is zero outside argument bytes
    a_idx_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_data.arg_index != 4'd0)
            |-> (r_o_data.field_kind == KIND_MIDDLE
                 || r_o_data.field_kind == KIND_TRAILER))
        else $error("arg_index set on a non-argument byte");

    // a line end is only reported on a terminator byte
    a_end_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_data.line_end)
            |-> (r_o_data.byte_out == CH_CR || r_o_data.byte_out == CH_LF))
        else $error("line_end on a non-terminator byte");

endmodule

`default_nettype wire

[bench/irc_tag_monitor.sv]
// Watches both channels of irc_line_token_parser, predicts the tag of every accepted byte
// and compares each result beat with it. Depends on irc_pkg (byte codes, kinds, t_result).
module irc_tag_monitor #(
    parameter int MAX_ARGUMENTS  = 15,
    parameter int MAX_LINE_BYTES = 510
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte channel
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_in_byte,
    // result channel
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_byte_out,
    input  wire logic [2:0] i_field_kind,
    input  wire logic [3:0] i_arg_index,
    input  wire logic       i_token_start,
    input  wire logic       i_line_end,
    input  wire logic [3:0] i_arg_total,
    input  wire logic       i_line_error,
    output int              o_fail_count,
    output int              o_pending
);
    import irc_pkg::*;

    typedef enum logic [2:0] {
        PH_LINE_START, PH_TRAILER_OPEN, PH_PREFIX, PH_CMD_WAIT,
        PH_COMMAND, PH_ARG_WAIT, PH_MIDDLE, PH_TRAILER
    } t_phase;

    t_phase     phase;
    logic [3:0] args_open;
    logic [8:0] line_len;
    logic       cr_pending;
    logic       too_long;
    t_result    expected_tags[$];
    int         mismatches = 0;

    // Tag one byte and advance the parse state.
    function automatic t_result tag_byte(input logic [7:0] b);
        t_result    r;
        logic [8:0] prior;
        logic       ws;
        r = '0;
        r.byte_out = b;
        r.field_kind = KIND_SEP;
        if (b == CH_CR || b == CH_LF) begin
            if (b == CH_LF && cr_pending) begin
                cr_pending = 1'b0;        // second half of CR LF
            end else begin
                if (line_len != 0 || too_long) begin
                    r.line_end   = 1'b1;
                    r.arg_total  = args_open;
                    r.line_error = too_long;
                end
                phase      = PH_LINE_START;
                args_open  = '0;
                line_len   = '0;
                too_long   = 1'b0;
                cr_pending = (b == CH_CR);
            end
            return r;
        end
        cr_pending = 1'b0;
        if (line_len >= MAX_LINE_BYTES) begin
            too_long = 1'b1;
            return r;
        end
        prior    = line_len;
        line_len = line_len + 9'd1;
        ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
        case (phase)
            PH_LINE_START: begin
                if (b == CH_COLON) begin
                    phase = PH_PREFIX;
                end else if (ws) begin
                    phase = PH_ARG_WAIT;
                end else begin
                    r.field_kind  = KIND_COMMAND;
                    r.token_start = 1'b1;
                    phase = PH_COMMAND;
                end
            end
            PH_PREFIX: begin
                if (ws) begin
                    phase = PH_CMD_WAIT;
                end else begin
                    r.field_kind  = KIND_PREFIX;
                    r.token_start = (prior == 9'd1);
                end
            end
            PH_CMD_WAIT: begin
                if (!ws) begin
                    r.field_kind  = KIND_COMMAND;
                    r.token_start = 1'b1;
                    phase = PH_COMMAND;
                end
            end
            PH_COMMAND: begin
                if (ws) phase = PH_ARG_WAIT;
                else r.field_kind = KIND_COMMAND;
            end
            PH_ARG_WAIT: begin
                if (!ws && args_open < MAX_ARGUMENTS) begin
                    if (b == CH_COLON) begin
                        phase = PH_TRAILER_OPEN;
                    end else begin
                        r.field_kind  = KIND_MIDDLE;
                        r.token_start = 1'b1;
                        r.arg_index   = args_open;
                        phase = PH_MIDDLE;
                    end
                    args_open = args_open + 4'd1;
                end
            end
            PH_MIDDLE: begin
                if (ws) begin
                    phase = PH_ARG_WAIT;
                end else begin
                    r.field_kind = KIND_MIDDLE;
                    r.arg_index  = args_open - 4'd1;
                end
            end
            PH_TRAILER_OPEN: begin
                r.field_kind  = KIND_TRAILER;
                r.token_start = 1'b1;
                r.arg_index   = args_open - 4'd1;
                phase = PH_TRAILER;
            end
            default: begin
                r.field_kind = KIND_TRAILER;
                r.arg_index  = args_open - 4'd1;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            phase      = PH_LINE_START;
            args_open  = '0;
            line_len   = '0;
            cr_pending = 1'b0;
            too_long   = 1'b0;
            expected_tags.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_tags.push_back(tag_byte(i_in_byte));
            if (i_out_valid && !i_out_stall) begin
                if (expected_tags.size() == 0) begin
                    $error("result beat 0x%02h with nothing expected", i_byte_out);
                    mismatches++;
                end else begin
                    want = expected_tags.pop_front();
                    check_field("byte_out",    want.byte_out,        i_byte_out);
                    check_field("field_kind",  8'(want.field_kind),  8'(i_field_kind));
                    check_field("arg_index",   8'(want.arg_index),   8'(i_arg_index));
                    check_field("token_start", 8'(want.token_start), 8'(i_token_start));
                    check_field("line_end",    8'(want.line_end),    8'(i_line_end));
                    check_field("arg_total",   8'(want.arg_total),   8'(i_arg_total));
                    check_field("line_error",  8'(want.line_error),  8'(i_line_error));
                end
            end
        end
        o_pending    = expected_tags.size();
        o_fail_count = mismatches;
    end

endmodule

[bench/tb.sv]
// Top of the bench for irc_line_token_parser: clock, reset, byte stimulus, result stalls
// and the verdict. Depends on irc_pkg and irc_tag_monitor, which does all the checking.
module tb;
    import irc_pkg::*;

    localparam int MAX_ARGUMENTS  = 15;
    localparam int MAX_LINE_BYTES = 510;
    localparam int N_DIRECTED     = 28;
    localparam int N_RANDOM       = 1700;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       byte_valid   = 1'b0;
    logic [7:0] byte_data    = 8'h00;
    logic       result_stall = 1'b0;

    wire logic       byte_stall;
    wire logic       result_valid;
    wire logic [7:0] res_byte;
    wire logic [2:0] res_kind;
    wire logic [3:0] res_index;
    wire logic       res_start;
    wire logic       res_end;
    wire logic [3:0] res_total;
    wire logic       res_error;

    int fail_count;
    int pending;
    int sent = 0;

    logic [7:0] line_bytes[$];

    // Short hand-written stream: prefix, command, middle and trailer with CR LF;
    // an empty CR LF and a lone empty LF; leading whitespace with a colon inside
    // a token, NUL and 0xFF ended by LF; an empty prefix (tab right after ':'),
    // VT and FF separators and an empty trailer ended by a bare CR.
    logic [7:0] directed [0:N_DIRECTED-1] = '{
        CH_COLON, "p", CH_SPACE, "C", CH_SPACE, "m", CH_SPACE, CH_COLON, "t",
        CH_CR, CH_LF,
        CH_CR, CH_LF, CH_LF,
        CH_SPACE, "a", CH_COLON, "b", 8'h00, 8'hFF, CH_LF,
        CH_COLON, CH_TAB, "X", CH_VT, CH_FF, CH_COLON, CH_CR
    };

    irc_line_token_parser #(
        .MAX_ARGUMENTS (MAX_ARGUMENTS),
        .MAX_LINE_BYTES(MAX_LINE_BYTES)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (byte_valid),
        .o_stall      (byte_stall),
        .i_data_byte  (byte_data),
        .o_valid      (result_valid),
        .i_stall      (result_stall),
        .o_byte_out   (res_byte),
        .o_field_kind (res_kind),
        .o_arg_index  (res_index),
        .o_token_start(res_start),
        .o_line_end   (res_end),
        .o_arg_total  (res_total),
        .o_line_error (res_error)
    );

    irc_tag_monitor #(
        .MAX_ARGUMENTS (MAX_ARGUMENTS),
        .MAX_LINE_BYTES(MAX_LINE_BYTES)
    ) tag_mon (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (byte_valid),
        .i_in_stall   (byte_stall),
        .i_in_byte    (byte_data),
        .i_out_valid  (result_valid),
        .i_out_stall  (result_stall),
        .i_byte_out   (res_byte),
        .i_field_kind (res_kind),
        .i_arg_index  (res_index),
        .i_token_start(res_start),
        .i_line_end   (res_end),
        .i_arg_total  (res_total),
        .i_line_error (res_error),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one byte beat. Called at a falling edge and returns at one, with
    // valid still high so back-to-back beats never drop valid in between.
    // Every third block of 64 beats goes out with no gaps at all.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = ((sent / 64) % 3 == 0) ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= b;
        do @(posedge clk); while (byte_stall);
        sent++;
        @(negedge clk);
    endtask

    // Any byte other than CR, LF and whitespace: colons, NUL and high bytes included.
    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF || b == CH_SPACE || b == CH_TAB ||
               b == CH_VT || b == CH_FF);
        return b;
    endfunction

    // Any byte other than a terminator; whitespace allowed (trailers, long lines).
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    task automatic add_token();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) line_bytes.push_back(token_byte());
    endtask

    // A run of one to three whitespace bytes of any of the four kinds.
    task automatic add_gap();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       line_bytes.push_back(CH_SPACE);
                1:       line_bytes.push_back(CH_TAB);
                2:       line_bytes.push_back(CH_VT);
                default: line_bytes.push_back(CH_FF);
            endcase
        end
    endtask

    // Stimulus
    initial begin : stimulus
        int  pick;
        int  n;
        bit  ends;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i]) send_byte(directed[i]);

        // Random lines. Mostly well-formed messages with random content; now
        // and then a line right around the length limit, bare terminators
        // (empty lines) and raw noise, which may break the next line too.
        while (sent < N_DIRECTED + N_RANDOM) begin
            line_bytes.delete();
            ends = 1'b1;
            pick = $urandom_range(0, 199);
            if (pick < 2) begin
                // straddles the limit: just under, exactly at, a few over
                n = MAX_LINE_BYTES - 2 + $urandom_range(0, 6);
                repeat (n) line_bytes.push_back(text_byte());
            end else if (pick < 30) begin
                n = $urandom_range(1, 12);
                repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
                ends = 1'($urandom_range(0, 1));
            end else if (pick < 40) begin
                // empty line: terminator only
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    line_bytes.push_back(CH_COLON);
                    if ($urandom_range(0, 7) != 0) add_token();
                    add_gap();
                end
                if ($urandom_range(0, 9) == 0) add_gap();
                add_token();
                // one line in ten draws 13 to 18 middle arguments, around the argument limit
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 18)
                                                : $urandom_range(0, 4);
                repeat (n) begin
                    add_gap();
                    add_token();
                end
                if ($urandom_range(0, 1)) begin
                    add_gap();
                    line_bytes.push_back(CH_COLON);
                    n = $urandom_range(0, 8);
                    repeat (n) line_bytes.push_back(text_byte());
                end
                if ($urandom_range(0, 5) == 0) add_gap();
            end
            if (ends) begin
                case ($urandom_range(0, 2))
                    0: line_bytes.push_back(CH_CR);
                    1: line_bytes.push_back(CH_LF);
                    default: begin
                        line_bytes.push_back(CH_CR);
                        line_bytes.push_back(CH_LF);
                    end
                endcase
            end
            foreach (line_bytes[i]) send_byte(line_bytes[i]);
        end
        byte_valid <= 1'b0;

        // drain: every expected beat back, then a wait for stragglers
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side. Draws a random stall before each beat, takes beats with no
    // stall at all in every third block of 80, and once, at beat 300, holds off
    // so the block fills both output registers and stalls its input.
    initial begin : receiver
        int n;
        int beats;
        beats = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (beats == 300)
                n = 64;
            else if ((beats / 80) % 3 == 1)
                n = 0;
            else
                n = $urandom_range(0, 5);
            repeat (n) begin
                result_stall <= 1'b1;
                @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            beats++;
            @(negedge clk);
        end
    end

endmodule
